// ===== rtl/core/pbdc_pkg.sv =====
package pbdc_pkg;

	// field widths
	localparam int unsigned ECHO_W     = 15;
	localparam int unsigned DIST_W     = 9;
	localparam int unsigned ELAPSED_W  = 10;
	localparam int unsigned PERIOD_W   = 10;

	// configuration port
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;
	localparam logic        REG_SAMPLE_PERIOD = 1'b0;
	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 10'd100;

	// item commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ECHO = 1'b1;

	// echo conversion: floor(us*17/1000) as (us * 17 * ceil(2^29/1000)) >> 29, exact below 359647
	localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;
	localparam int unsigned       ECHO_MULT_W     = 24;
	localparam logic [ECHO_MULT_W-1:0] ECHO_CM_MULT = 24'd9126807;
	localparam int unsigned       ECHO_CM_SHIFT   = 29;
	localparam int unsigned       ECHO_PROD_W     = ECHO_W + ECHO_MULT_W;

	// buzzer ranges
	localparam logic [DIST_W-1:0] NEAR_LIMIT_CM = 9'd5;
	localparam logic [DIST_W-1:0] FAR_LIMIT_CM  = 9'd50;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 10'd1023;
	localparam int unsigned MIN_INTERVAL_MS = 40;
	localparam int unsigned MAX_INTERVAL_MS = 800;
	localparam int unsigned TAB_IDX_W = 6;
	localparam int unsigned TAB_DEPTH = 1 << TAB_IDX_W;

	typedef logic [ELAPSED_W-1:0] interval_tab_t [TAB_DEPTH];

	// toggle interval per distance, only mid-range entries are meaningful
	function automatic interval_tab_t build_interval_tab();
		interval_tab_t tab;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			if (i > 5 && i < 50)
				tab[i] = ELAPSED_W'(((i - 5) * (MAX_INTERVAL_MS - MIN_INTERVAL_MS)) / 45
					+ MIN_INTERVAL_MS);
			else
				tab[i] = '0;
		end
		return tab;
	endfunction

	localparam interval_tab_t BEEP_INTERVAL = build_interval_tab();

	typedef struct packed {
		logic              cmd;
		logic [ECHO_W-1:0] echo_us;
	} in_item_t;

	typedef struct packed {
		logic              tone_on;
		logic              measure_request;
		logic [DIST_W-1:0] distance_cm;
		logic              no_echo;
	} out_item_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] sample_elapsed;
		logic [ELAPSED_W-1:0] beep_elapsed;
		logic [DIST_W-1:0]    stored_distance;
		logic                 beep_phase;
		logic                 tone_state;
	} beep_state_t;

endpackage

// ===== rtl/core/pbdc_step.sv =====
module pbdc_step (
	input  pbdc_pkg::in_item_t            item,
	input  pbdc_pkg::beep_state_t         state,
	input  logic [pbdc_pkg::PERIOD_W-1:0] period,
	output pbdc_pkg::beep_state_t         state_nxt,
	output pbdc_pkg::out_item_t           result
);

	logic [pbdc_pkg::ECHO_PROD_W-1:0] echo_prod;
	logic                             echo_ok;
	logic [pbdc_pkg::DIST_W-1:0]      echo_cm;
	logic [pbdc_pkg::ELAPSED_W:0]     sample_sum;
	logic                             req;
	logic [pbdc_pkg::ELAPSED_W-1:0]   beep_inc;
	logic [pbdc_pkg::ELAPSED_W-1:0]   interval;
	logic [pbdc_pkg::DIST_W-1:0]      d;

	// echo width to centimetres by reciprocal multiply
	assign echo_prod = pbdc_pkg::ECHO_PROD_W'(item.echo_us)
		* pbdc_pkg::ECHO_PROD_W'(pbdc_pkg::ECHO_CM_MULT);
	assign echo_ok   = (item.echo_us != '0) && (item.echo_us <= pbdc_pkg::ECHO_TIMEOUT_US);
	assign echo_cm   = echo_ok
		? echo_prod[pbdc_pkg::ECHO_CM_SHIFT +: pbdc_pkg::DIST_W] : '0;

	// sample period counter
	assign sample_sum = {1'b0, state.sample_elapsed} + 1'b1;
	assign req        = sample_sum >= {1'b0, period};

	// saturating beep counter and interval lookup
	assign d        = state.stored_distance;
	assign beep_inc = (state.beep_elapsed < pbdc_pkg::ELAPSED_MAX)
		? state.beep_elapsed + 1'b1 : state.beep_elapsed;
	assign interval = pbdc_pkg::BEEP_INTERVAL[d[pbdc_pkg::TAB_IDX_W-1:0]];

	// next state
	always_comb begin
		state_nxt = state;
		if (item.cmd == pbdc_pkg::CMD_ECHO) begin
			state_nxt.stored_distance = echo_cm;
		end else begin
			state_nxt.sample_elapsed = req ? '0 : sample_sum[pbdc_pkg::ELAPSED_W-1:0];
			state_nxt.beep_elapsed   = beep_inc;
			if (d != '0 && d <= pbdc_pkg::NEAR_LIMIT_CM) begin
				state_nxt.tone_state = 1'b1;
			end else if (d > pbdc_pkg::NEAR_LIMIT_CM && d < pbdc_pkg::FAR_LIMIT_CM) begin
				if (beep_inc >= interval) begin
					state_nxt.beep_elapsed = '0;
					state_nxt.beep_phase   = ~state.beep_phase;
					state_nxt.tone_state   = ~state.beep_phase;
				end
			end else begin
				state_nxt.tone_state = 1'b0;
			end
		end
	end

	// result item
	always_comb begin
		result.tone_on         = state_nxt.tone_state;
		result.measure_request = (item.cmd == pbdc_pkg::CMD_TICK) && req;
		result.distance_cm     = state_nxt.stored_distance;
		result.no_echo         = (state_nxt.stored_distance == '0);
	end

endmodule

// ===== rtl/core/parking_beep_distance_controller.sv =====
// channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------------------
// item      | item_valid / item_ready        | item (cmd, echo_us)
// result    | result_valid / result_ready    | result (tone_on, measure_request, ...)
// config    | psel penable pwrite pready     | paddr, pwdata, prdata (sample_period_ms)
//
// One item per cycle sustained unless the result stalls; each item goes through the input
// register, then one pass of counter, compare and echo multiply logic into the result register.
// Result valid is set as the item moves into the result register; a stalled result delays this.
// A stalled result holds the input register full; item_ready drops only when both are full.
// arst_n clears counters, stored distance and tone state, and sets the period register to 100 ms.
module parking_beep_distance_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  pbdc_pkg::in_item_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output pbdc_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbdc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pbdc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pbdc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	pbdc_pkg::in_item_t            item_s1;
	logic                          item_v_s1;
	pbdc_pkg::out_item_t           result_q;
	logic                          result_v_q;
	pbdc_pkg::beep_state_t         state_q;
	pbdc_pkg::beep_state_t         state_nxt;
	pbdc_pkg::out_item_t           step_result;
	logic [pbdc_pkg::PERIOD_W-1:0] period_q;
	logic                          advance;
	logic                          reg_sel;

	// register decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[pbdc_pkg::PADDR_W-1] == pbdc_pkg::REG_SAMPLE_PERIOD);
	assign prdata  = reg_sel ? pbdc_pkg::PDATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= pbdc_pkg::SAMPLE_PERIOD_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			period_q <= pwdata[pbdc_pkg::PERIOD_W-1:0];
		end
	end

	// flow control
	assign advance    = item_v_s1 && (!result_v_q || result_ready);
	assign item_ready = !item_v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (item_ready) begin
			item_v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	// per-item update
	pbdc_step u_step (
		.item      (item_s1),
		.state     (state_q),
		.period    (period_q),
		.state_nxt (state_nxt),
		.result    (step_result)
	);

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			result_v_q <= 1'b0;
		end else if (advance) begin
			state_q    <= state_nxt;
			result_v_q <= 1'b1;
		end else if (result_ready) begin
			result_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= step_result;
	end

	assign result_valid = result_v_q;
	assign result       = result_q;

	// echo items leave counters and tone untouched
	a_echo_keeps_timing: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == pbdc_pkg::CMD_ECHO |=>
		$stable(state_q.sample_elapsed) && $stable(state_q.beep_elapsed)
		&& $stable(state_q.tone_state) && $stable(state_q.beep_phase))
		else $error("echo item changed timing state");

	// a measure request restarts the sample count
	a_request_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_result.measure_request |=> state_q.sample_elapsed == '0)
		else $error("sample count not cleared on request");

	// steady tone when very close
	a_near_tone: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == pbdc_pkg::CMD_TICK && state_q.stored_distance != '0
		&& state_q.stored_distance <= pbdc_pkg::NEAR_LIMIT_CM |=> state_q.tone_state)
		else $error("tone not steady in near range");

	// stored distance stays within conversion range
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.stored_distance <= 9'd510)
		else $error("stored distance out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// tracks the beeper state and keeps the outputs still owed by the block
	class beeper_shadow;
		logic [pbdc_pkg::PERIOD_W-1:0] period;
		int unsigned sample_cnt;
		int unsigned beep_cnt;
		int unsigned dist_cm;
		bit phase;
		bit tone;
		pbdc_pkg::out_item_t awaited_beeps[$];
		int unsigned errors;

		function new();
			period = pbdc_pkg::SAMPLE_PERIOD_RST;
			sample_cnt = 0;
			beep_cnt = 0;
			dist_cm = 0;
			phase = 1'b0;
			tone = 1'b0;
			errors = 0;
		endfunction

		function void set_period(logic [pbdc_pkg::PDATA_W-1:0] value);
			period = value[pbdc_pkg::PERIOD_W-1:0];
		endfunction

		function void note_item(pbdc_pkg::in_item_t it);
			pbdc_pkg::out_item_t want;
			int unsigned interval;
			bit req;
			req = 1'b0;
			if (it.cmd == pbdc_pkg::CMD_ECHO) begin
				// pulse width to centimetres, out of range counts as no echo
				if (it.echo_us == '0 || it.echo_us > pbdc_pkg::ECHO_TIMEOUT_US)
					dist_cm = 0;
				else
					dist_cm = (int'(it.echo_us) * 17) / 1000;
			end else begin
				// sample period counter
				sample_cnt = sample_cnt + 1;
				if (sample_cnt >= period) begin
					req = 1'b1;
					sample_cnt = 0;
				end
				if (beep_cnt < pbdc_pkg::ELAPSED_MAX)
					beep_cnt = beep_cnt + 1;
				// buzzer rules on the stored distance
				if (dist_cm >= 1 && dist_cm <= pbdc_pkg::NEAR_LIMIT_CM) begin
					tone = 1'b1;
				end else if (dist_cm > pbdc_pkg::NEAR_LIMIT_CM
					&& dist_cm < pbdc_pkg::FAR_LIMIT_CM) begin
					interval = (dist_cm - pbdc_pkg::NEAR_LIMIT_CM)
						* (pbdc_pkg::MAX_INTERVAL_MS - pbdc_pkg::MIN_INTERVAL_MS)
						/ (pbdc_pkg::FAR_LIMIT_CM - pbdc_pkg::NEAR_LIMIT_CM)
						+ pbdc_pkg::MIN_INTERVAL_MS;
					if (beep_cnt >= interval) begin
						beep_cnt = 0;
						phase = ~phase;
						tone = phase;
					end
				end else begin
					tone = 1'b0;
				end
			end
			want.tone_on = tone;
			want.measure_request = req;
			want.distance_cm = pbdc_pkg::DIST_W'(dist_cm);
			want.no_echo = (dist_cm == 0);
			awaited_beeps.push_back(want);
		endfunction

		function void check_result(pbdc_pkg::out_item_t got);
			pbdc_pkg::out_item_t want;
			if (awaited_beeps.size() == 0) begin
				$error("result %h arrived with nothing awaited", got);
				errors++;
				return;
			end
			want = awaited_beeps.pop_front();
			if (got.tone_on !== want.tone_on) begin
				$error("tone_on: expected %0d, got %0d", want.tone_on, got.tone_on);
				errors++;
			end
			if (got.measure_request !== want.measure_request) begin
				$error("measure_request: expected %0d, got %0d", want.measure_request,
					got.measure_request);
				errors++;
			end
			if (got.distance_cm !== want.distance_cm) begin
				$error("distance_cm: expected %0d, got %0d", want.distance_cm, got.distance_cm);
				errors++;
			end
			if (got.no_echo !== want.no_echo) begin
				$error("no_echo: expected %0d, got %0d", want.no_echo, got.no_echo);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pbdc_pkg::in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	pbdc_pkg::out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pbdc_pkg::PADDR_W-1:0] paddr = '0;
	logic [pbdc_pkg::PDATA_W-1:0] pwdata = '0;
	logic [pbdc_pkg::PDATA_W-1:0] prdata;
	logic pready;

	beeper_shadow shadow = new();
	int unsigned send_idle_pct = 17;
	int unsigned recv_idle_pct = 88;
	int unsigned sent = 0;

	parking_beep_distance_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	// watch both channels at the clock edge
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			shadow.note_item(item);
		if (arst_n && result_valid && result_ready)
			shadow.check_result(result);
	end

	// receiver stalls
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hand one item over, with random gaps before it
	task automatic push_item(input logic cmd, input logic [pbdc_pkg::ECHO_W-1:0] us);
		pbdc_pkg::in_item_t it;
		it.cmd = cmd;
		it.echo_us = us;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic push_ticks(input int unsigned n);
		repeat (n)
			push_item(pbdc_pkg::CMD_TICK, pbdc_pkg::ECHO_W'($urandom));
	endtask

	// hold the sender until every awaited output is in
	task automatic drain_beeps();
		item_valid <= 1'b0;
		@(posedge clk);
		while (shadow.awaited_beeps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// period register write, only with the block idle
	task automatic write_period(input logic [pbdc_pkg::PDATA_W-1:0] value);
		drain_beeps();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pbdc_pkg::PADDR_W'(4 * pbdc_pkg::REG_SAMPLE_PERIOD);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow.set_period(value);
	endtask

	// echo width aimed at one of the distance bands
	function automatic logic [pbdc_pkg::ECHO_W-1:0] pick_echo();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return pbdc_pkg::ECHO_W'($urandom_range(30001, 32767));
		else if (r < 15)
			return pbdc_pkg::ECHO_W'($urandom_range(1, 58));
		else if (r < 35)
			return pbdc_pkg::ECHO_W'($urandom_range(59, 352));
		else if (r < 60)
			return pbdc_pkg::ECHO_W'($urandom_range(353, 700));
		else if (r < 75)
			return pbdc_pkg::ECHO_W'($urandom_range(701, 2941));
		else
			return pbdc_pkg::ECHO_W'($urandom_range(2942, 30000));
	endfunction

	// echo followed by a run of ticks, with some noise and sender pauses
	task automatic run_random(input int unsigned n_items);
		int unsigned start;
		int unsigned k;
		start = sent;
		while (sent - start < n_items) begin
			k = $urandom_range(99);
			if (k < 10) begin
				push_item(1'($urandom_range(1)), pbdc_pkg::ECHO_W'($urandom));
			end else if (k < 12) begin
				drain_beeps();
			end else begin
				push_item(pbdc_pkg::CMD_ECHO, pick_echo());
				push_ticks(($urandom_range(9) == 0) ? $urandom_range(150, 400)
					: $urandom_range(1, 60));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// distance bands and their edges, with the reset period
		push_item(pbdc_pkg::CMD_TICK, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'h7FFF);
		push_item(pbdc_pkg::CMD_ECHO, 15'd30001);
		push_item(pbdc_pkg::CMD_ECHO, 15'd58);
		push_item(pbdc_pkg::CMD_ECHO, 15'd59);
		push_item(pbdc_pkg::CMD_TICK, 15'h7FFF);
		push_item(pbdc_pkg::CMD_ECHO, 15'd352);
		push_item(pbdc_pkg::CMD_TICK, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'd353);
		push_item(pbdc_pkg::CMD_TICK, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'd2941);
		push_item(pbdc_pkg::CMD_TICK, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'd2942);
		push_item(pbdc_pkg::CMD_TICK, 15'd0);
		push_item(pbdc_pkg::CMD_ECHO, 15'd30000);
		push_item(pbdc_pkg::CMD_TICK, 15'd0);

		// zero period, top of the register, stray upper bits
		write_period(32'd0);
		push_ticks(3);
		write_period(32'd1023);
		push_ticks(2);
		write_period(32'hFFFF_FC02);
		push_ticks(3);

		// sender mostly busy, receiver mostly stalled
		write_period(32'd1);
		run_random(110);

		// the other way round
		write_period(32'd1000);
		send_idle_pct = 88;
		recv_idle_pct = 17;
		run_random(110);

		// no idling; long far run saturates the beep counter before a mid echo
		write_period(pbdc_pkg::PDATA_W'($urandom_range(3, 50)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_item(pbdc_pkg::CMD_ECHO, 15'd5000);
		push_ticks(1030);
		push_item(pbdc_pkg::CMD_ECHO, 15'd400);
		push_ticks(4);
		run_random(80);

		drain_beeps();
		if (shadow.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/pbdc_pkg.sv
rtl/core/pbdc_step.sv
rtl/core/parking_beep_distance_controller.sv
test/tb.sv
